[rtl/msq_pkg.sv]
// Shared types and constants for the melody note sequencer.
package msq_pkg;

    localparam int ADC_W      = 12;
    localparam int POS_W      = 8;
    localparam int PERIOD_W   = 16;
    localparam int LENGTH_W   = 8;
    localparam int TICKS_W    = 16;
    localparam int COUNT_W    = 9;
    localparam int ELAPSED_W  = 24;
    localparam int SAMPLE_W   = 5;
    localparam int VOL_W      = 7;
    localparam int LED_W      = 8;
    localparam int SONG_OUT_W = 3;
    localparam int SLOT_W     = 2;

    localparam int VOL_FULL   = 100;
    localparam int LED_OFFSET = 3;

    localparam logic [1:0] MODE_TICK   = 2'd0;
    localparam logic [1:0] MODE_BUTTON = 2'd1;
    localparam logic [1:0] MODE_NOTE   = 2'd2;
    localparam logic [1:0] MODE_SONG   = 2'd3;

    typedef struct packed {
        logic [ADC_W-1:0]    adc_sample;
        logic [SLOT_W-1:0]   song_slot;
        logic [POS_W-1:0]    note_index;
        logic [PERIOD_W-1:0] note_period;
        logic [LENGTH_W-1:0] note_length;
        logic [TICKS_W-1:0]  unit_ticks;
        logic [TICKS_W-1:0]  gap_ticks;
        logic [COUNT_W-1:0]  note_count;
    } t_item;

    typedef struct packed {
        logic                  tone_on;
        logic [PERIOD_W-1:0]   tone_period;
        logic [VOL_W-1:0]      volume_percent;
        logic [LED_W-1:0]      led_mask;
        logic [SONG_OUT_W-1:0] current_song;
        logic [POS_W-1:0]      current_note;
    } t_result;

endpackage

[rtl/msq_note_mem.sv]
// Note store: period and length per song slot and position, registered read with write bypass.
module msq_note_mem
    import msq_pkg::*;
#(
    parameter int SONGS     = 4,
    parameter int MAX_NOTES = 256,
    parameter int SNW       = 3
) (
    input  logic                i_clk,
    input  logic                i_wr_en,
    input  logic [SLOT_W-1:0]   i_wr_slot,
    input  logic [POS_W-1:0]    i_wr_index,
    input  logic [PERIOD_W-1:0] i_wr_period,
    input  logic [LENGTH_W-1:0] i_wr_length,
    input  logic [SNW-1:0]      i_rd_song,
    input  logic [POS_W-1:0]    i_rd_pos,
    output logic [PERIOD_W-1:0] o_rd_period,
    output logic [LENGTH_W-1:0] o_rd_length
);

    localparam int DEPTH = SONGS * MAX_NOTES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DW    = PERIOD_W + LENGTH_W;

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_data;
    logic [DW-1:0] r_byp_data;
    logic          r_byp;

    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic [DW-1:0] wr_data;
    logic [DW-1:0] rd_word;

    always_comb begin
        wr_addr = AW'(int'(i_wr_slot) * MAX_NOTES + int'(i_wr_index));
        // song 0 plays nothing, so its address is a don't-care
        rd_addr = (i_rd_song == '0) ? AW'(int'(i_rd_pos))
                : AW'((int'(i_rd_song) - 1) * MAX_NOTES + int'(i_rd_pos));
        wr_data = {i_wr_period, i_wr_length};
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data  <= r_mem[rd_addr];
        r_byp      <= i_wr_en && (wr_addr == rd_addr);
        r_byp_data <= wr_data;
    end

    assign rd_word     = r_byp ? r_byp_data : r_rd_data;
    assign o_rd_period = rd_word[DW-1:LENGTH_W];
    assign o_rd_length = rd_word[LENGTH_W-1:0];

endmodule

[rtl/msq_core.sv]
// Sequencer state, song settings and the per-word update logic.
module msq_core
    import msq_pkg::*;
#(
    parameter int SONGS           = 4,
    parameter int MAX_NOTES       = 256,
    parameter int ADC_MAX         = 4095,
    parameter int SAMPLE_INTERVAL = 20,
    parameter int SNW             = 3
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [1:0]          i_mode,
    input  t_item               i_item,
    input  logic [PERIOD_W-1:0] i_rd_period,
    input  logic [LENGTH_W-1:0] i_rd_length,
    output logic                o_wr_en,
    output logic [SNW-1:0]      o_rd_song,
    output logic [POS_W-1:0]    o_rd_pos,
    output t_result             o_result
);

    localparam int SIW = (SONGS > 1) ? $clog2(SONGS) : 1;
    // volume = adc*100/ADC_MAX as one multiply by a scaled reciprocal
    localparam int NUM_W = ADC_W + 7;
    localparam int VOL_SH = NUM_W + $clog2(ADC_MAX);
    localparam longint VOL_M = ((64'sd1 <<< VOL_SH) + ADC_MAX - 1) / ADC_MAX;
    localparam longint VOL_C = 100 * VOL_M;
    localparam int VOL_CW = $clog2(VOL_C + 1);
    localparam int PW = ADC_W + VOL_CW;

    typedef enum logic [1:0] {
        PH_START,
        PH_SOUND,
        PH_GAP
    } t_phase;

    t_phase                r_phase, n_phase;
    logic                  r_pending, n_pending;
    logic [SNW-1:0]        r_song, n_song;
    logic [POS_W-1:0]      r_pos, n_pos;
    logic [ELAPSED_W-1:0]  r_elapsed, n_elapsed;
    logic [SAMPLE_W-1:0]   r_sample, n_sample;
    logic [VOL_W-1:0]      r_vol, n_vol;
    logic                  r_run, n_run;
    logic [PERIOD_W-1:0]   r_period, n_period;
    logic [LED_W-1:0]      r_led, n_led;

    logic [TICKS_W-1:0]    r_unit [SONGS];
    logic [TICKS_W-1:0]    r_gap  [SONGS];
    logic [COUNT_W-1:0]    r_count[SONGS];

    logic [SIW-1:0]        cur_slot;
    logic [SIW-1:0]        wr_slot;
    logic                  slot_ok;
    logic                  set_wr;
    logic [ELAPSED_W-1:0]  dur;
    logic [PW-1:0]         vol_prod;
    logic [PW-1:0]         vol_q;
    logic [VOL_W-1:0]      vol_new;
    logic [COUNT_W-1:0]    next_pos;
    logic [4:0]            led_bit;

    always_comb begin
        cur_slot = SIW'(r_song - SNW'(1));
        wr_slot  = SIW'(i_item.song_slot);
        slot_ok  = (int'(i_item.song_slot) < SONGS);
        set_wr   = i_accept && (i_mode == MODE_SONG) && slot_ok;
        o_wr_en  = i_accept && (i_mode == MODE_NOTE) && slot_ok
                   && (int'(i_item.note_index) < MAX_NOTES);
        dur      = ELAPSED_W'(r_unit[cur_slot]) * ELAPSED_W'(i_rd_length);
        vol_prod = PW'(i_item.adc_sample) * PW'(VOL_C);
        vol_q    = vol_prod >> VOL_SH;
        vol_new  = (vol_q > PW'(VOL_FULL)) ? VOL_W'(VOL_FULL) : VOL_W'(vol_q);
        next_pos = COUNT_W'(r_pos) + COUNT_W'(1);
    end

    always_comb begin
        n_phase   = r_phase;
        n_pending = r_pending;
        n_song    = r_song;
        n_pos     = r_pos;
        n_elapsed = r_elapsed;
        n_sample  = r_sample;
        n_vol     = r_vol;
        n_run     = r_run;
        n_period  = r_period;
        n_led     = r_led;
        led_bit   = '0;
        if (i_accept) begin
            case (i_mode)
                MODE_TICK: begin
                    if (r_elapsed != '1) begin
                        n_elapsed = r_elapsed + ELAPSED_W'(1);
                    end
                    n_sample = r_sample + SAMPLE_W'(1);
                    if (n_sample >= SAMPLE_W'(SAMPLE_INTERVAL)) begin
                        n_vol    = vol_new;
                        n_sample = '0;
                    end
                    if (r_pending) begin
                        // restart: next song, LED, back to note 0
                        n_run     = 1'b0;
                        n_song    = (int'(r_song) == SONGS) ? '0 : r_song + SNW'(1);
                        led_bit   = 5'(n_song) + 5'(LED_OFFSET);
                        n_led     = (led_bit < 5'(LED_W)) ? (LED_W'(1) << led_bit[2:0]) : '0;
                        n_pos     = '0;
                        n_phase   = PH_START;
                        n_pending = 1'b0;
                    end else if (r_song != '0) begin
                        case (r_phase)
                            PH_START: begin
                                n_elapsed = '0;
                                if (i_rd_period != '0) begin
                                    n_period = i_rd_period;
                                    n_run    = 1'b1;
                                end
                                n_phase = PH_SOUND;
                            end
                            PH_SOUND: begin
                                if (n_elapsed >= dur) begin
                                    n_run     = 1'b0;
                                    n_phase   = PH_GAP;
                                    n_elapsed = '0;
                                end
                            end
                            PH_GAP: begin
                                if (n_elapsed >= ELAPSED_W'(r_gap[cur_slot])) begin
                                    n_phase = PH_START;
                                    // wrap at the song's count, the store depth or 256
                                    if (next_pos >= r_count[cur_slot] || next_pos[POS_W]
                                        || (11'(next_pos) >= 11'(MAX_NOTES))) begin
                                        n_pos = '0;
                                    end else begin
                                        n_pos = POS_W'(next_pos);
                                    end
                                end
                            end
                            default: begin
                                n_phase = PH_START;
                            end
                        endcase
                    end
                end
                MODE_BUTTON: begin
                    n_pending = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_START;
            r_pending <= 1'b0;
            r_song    <= '0;
            r_pos     <= '0;
            r_elapsed <= '0;
            r_sample  <= '0;
            r_vol     <= '0;
            r_run     <= 1'b0;
            r_period  <= '0;
            r_led     <= '0;
        end else begin
            r_phase   <= n_phase;
            r_pending <= n_pending;
            r_song    <= n_song;
            r_pos     <= n_pos;
            r_elapsed <= n_elapsed;
            r_sample  <= n_sample;
            r_vol     <= n_vol;
            r_run     <= n_run;
            r_period  <= n_period;
            r_led     <= n_led;
        end
    end

    always_ff @(posedge i_clk) begin
        if (set_wr) begin
            r_unit[wr_slot]  <= i_item.unit_ticks;
            r_gap[wr_slot]   <= i_item.gap_ticks;
            r_count[wr_slot] <= i_item.note_count;
        end
    end

    assign o_rd_song = n_song;
    assign o_rd_pos  = n_pos;

    always_comb begin
        o_result.tone_on        = n_run;
        o_result.tone_period    = n_period;
        o_result.volume_percent = n_vol;
        o_result.led_mask       = n_led;
        o_result.current_song   = SONG_OUT_W'(n_song);
        o_result.current_note   = n_pos;
    end

    a_vol_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vol <= VOL_W'(VOL_FULL))
        else $error("volume above full scale");

    a_led_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(r_led))
        else $error("more than one LED lit");

    a_silent_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_song == '0) |-> !r_run)
        else $error("tone running with no song selected");

    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && (i_mode == MODE_TICK) && r_pending)
        |=> (r_pos == '0) && !r_run && !r_pending && (r_phase == PH_START))
        else $error("restart tick did not rewind the song");

endmodule

[rtl/msq_out_buf.sv]
// Two-word result buffer between the sequencer and the output stream.
module msq_out_buf
    import msq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_result,
    output logic    o_ready,
    output logic    o_valid,
    input  logic    i_pop_ready,
    output t_result o_result
);

    logic [1:0] r_count;
    t_result    r_head;
    t_result    r_tail;
    logic       pop;

    assign pop      = o_valid && i_pop_ready;
    assign o_valid  = (r_count != 2'd0);
    assign o_ready  = (r_count != 2'd2);
    assign o_result = r_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else begin
            case (r_count)
                2'd0: begin
                    if (i_push) begin
                        r_count <= 2'd1;
                    end
                end
                2'd1: begin
                    if (i_push && !pop) begin
                        r_count <= 2'd2;
                    end else if (!i_push && pop) begin
                        r_count <= 2'd0;
                    end
                end
                2'd2: begin
                    if (pop) begin
                        r_count <= 2'd1;
                    end
                end
                default: begin
                    r_count <= 2'd0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_count == 2'd2 && pop) begin
            r_head <= r_tail;
        end else if (i_push && (r_count == 2'd0 || (r_count == 2'd1 && pop))) begin
            r_head <= i_result;
        end
        if (i_push && r_count == 2'd1 && !pop) begin
            r_tail <= i_result;
        end
    end

    a_count_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("result buffer count corrupt");

    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !pop) |=> (r_count == $past(r_count) + 2'd1))
        else $error("pushed word lost");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_push && pop) |=> (r_count == $past(r_count) - 2'd1))
        else $error("popped word not removed");

endmodule

[rtl/melody_note_sequencer.sv]
// Top level of the melody note sequencer: stream ports, core, note store and result buffer.
//
//  channel   dir  ports                      word
//  s_axis    in   tvalid/tready/tdata/tuser  one event: tick, button, note or song load
//  m_axis    out  tvalid/tready/tdata        sequencer outputs after that event
//
// Every accepted word yields exactly one result word, in order.
// An event is taken each cycle while the buffer has room; its result is set by the single
// update pass between the state registers and the result buffer, which registers it.
// The note store is read ahead at the next note's address, registered with the state; a
// write to that address is bypassed, so back-to-back loads and ticks need no stall.
// Reset (i_rst_n low, synchronous) clears the player state and empties the buffer;
// the note store and song settings hold garbage until loaded.
// If m_axis stalls, two results are held; o_s_axis_tready drops only when both are full.
module melody_note_sequencer
    import msq_pkg::*;
#(
    parameter int SONGS           = 4,
    parameter int MAX_NOTES       = 256,
    parameter int ADC_MAX         = 4095,
    parameter int SAMPLE_INTERVAL = 20
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [11:0] adc_sample, [13:12] song_slot, [21:14] note_index, [37:22] note_period,
    // [45:38] note_length, [61:46] unit_ticks, [77:62] gap_ticks, [86:78] note_count,
    // [87] zero
    input  logic [87:0] i_s_axis_tdata,
    // [1:0] mode
    input  logic [1:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [0] tone_on, [16:1] tone_period, [23:17] volume_percent, [31:24] led_mask,
    // [34:32] current_song, [42:35] current_note, [47:43] zero
    output logic [47:0] o_m_axis_tdata
);

    // song number runs 0..SONGS
    localparam int SNW = $clog2(SONGS + 1);

    logic                accept;
    t_item               item;
    t_result             core_result;
    t_result             out_result;
    logic                wr_en;
    logic [SNW-1:0]      rd_song;
    logic [POS_W-1:0]    rd_pos;
    logic [PERIOD_W-1:0] rd_period;
    logic [LENGTH_W-1:0] rd_length;
    logic                buf_ready;

    assign o_s_axis_tready = buf_ready;
    assign accept          = i_s_axis_tvalid && buf_ready;

    always_comb begin
        item.adc_sample  = i_s_axis_tdata[11:0];
        item.song_slot   = i_s_axis_tdata[13:12];
        item.note_index  = i_s_axis_tdata[21:14];
        item.note_period = i_s_axis_tdata[37:22];
        item.note_length = i_s_axis_tdata[45:38];
        item.unit_ticks  = i_s_axis_tdata[61:46];
        item.gap_ticks   = i_s_axis_tdata[77:62];
        item.note_count  = i_s_axis_tdata[86:78];
    end

    msq_core #(
        .SONGS           (SONGS),
        .MAX_NOTES       (MAX_NOTES),
        .ADC_MAX         (ADC_MAX),
        .SAMPLE_INTERVAL (SAMPLE_INTERVAL),
        .SNW             (SNW)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_mode      (i_s_axis_tuser),
        .i_item      (item),
        .i_rd_period (rd_period),
        .i_rd_length (rd_length),
        .o_wr_en     (wr_en),
        .o_rd_song   (rd_song),
        .o_rd_pos    (rd_pos),
        .o_result    (core_result)
    );

    msq_note_mem #(
        .SONGS     (SONGS),
        .MAX_NOTES (MAX_NOTES),
        .SNW       (SNW)
    ) u_note_mem (
        .i_clk       (i_clk),
        .i_wr_en     (wr_en),
        .i_wr_slot   (item.song_slot),
        .i_wr_index  (item.note_index),
        .i_wr_period (item.note_period),
        .i_wr_length (item.note_length),
        .i_rd_song   (rd_song),
        .i_rd_pos    (rd_pos),
        .o_rd_period (rd_period),
        .o_rd_length (rd_length)
    );

    msq_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (accept),
        .i_result    (core_result),
        .o_ready     (buf_ready),
        .o_valid     (o_m_axis_tvalid),
        .i_pop_ready (i_m_axis_tready),
        .o_result    (out_result)
    );

    assign o_m_axis_tdata = {5'b0,
                             out_result.current_note,
                             out_result.current_song,
                             out_result.led_mask,
                             out_result.volume_percent,
                             out_result.tone_period,
                             out_result.tone_on};

endmodule

[bench/tb_melody_note_sequencer.sv]
// Self-checking bench for the melody note sequencer: scripted and random events against a player model.
`timescale 1ns / 100ps

module tb_melody_note_sequencer;
    import msq_pkg::*;

    localparam int SONG_COUNT  = 4;
    localparam int NOTE_SLOTS  = 256;
    localparam int ADC_FULL    = 4095;
    localparam int VOL_EVERY   = 20;
    localparam int HOLD_CYCLES = 300;   // long receiver hold-off, enough to back up the input

    typedef enum logic [1:0] {PH_START, PH_SOUND, PH_GAP} t_note_phase;

    // one scripted word; want is used only where typed is set
    typedef struct {
        logic [1:0] mode;
        t_item      item;
        bit         typed;
        t_result    want;
    } t_script_row;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic [87:0] in_data   = '0;
    logic [1:0]  in_kind   = MODE_TICK;
    logic        in_ready;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [47:0] out_data;

    // pacing knobs, percent of cycles spent idle or stalled
    int src_idle  = 0;
    int dst_stall = 0;

    // long hold-off: flipping hold_kick starts a count in the receiver process
    bit hold_kick = 1'b0;
    bit hold_seen = 1'b0;
    int hold_left = 0;

    int n_sent    = 0;
    int n_outputs = 0;
    int n_faults  = 0;

    t_script_row script[$];
    t_result     due_outputs[$];

    // player model: state after reset
    t_note_phase pl_phase   = PH_START;
    bit          pl_armed   = 1'b0;
    logic [2:0]  pl_song    = '0;
    logic [7:0]  pl_note    = '0;
    logic [23:0] pl_elapsed = '0;
    logic [4:0]  pl_sample  = '0;
    logic [6:0]  pl_volume  = '0;
    bit          pl_tone    = 1'b0;
    logic [15:0] pl_period  = '0;
    logic [7:0]  pl_leds    = '0;
    logic [15:0] pl_note_period [SONG_COUNT][NOTE_SLOTS];
    logic [7:0]  pl_note_len    [SONG_COUNT][NOTE_SLOTS];
    logic [15:0] pl_unit  [SONG_COUNT];
    logic [15:0] pl_gap   [SONG_COUNT];
    logic [8:0]  pl_count [SONG_COUNT];

    // which note entries hold data, and how many lead off each song unbroken;
    // note counts never go past that run, so no tick reads an empty entry
    bit note_loaded [SONG_COUNT][NOTE_SLOTS];
    int loaded_run  [SONG_COUNT] = '{default: 0};

    melody_note_sequencer #(
        .SONGS           (SONG_COUNT),
        .MAX_NOTES       (NOTE_SLOTS),
        .ADC_MAX         (ADC_FULL),
        .SAMPLE_INTERVAL (VOL_EVERY)
    ) i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (in_valid),
        .o_s_axis_tready (in_ready),
        .i_s_axis_tdata  (in_data),
        .i_s_axis_tuser  (in_kind),
        .o_m_axis_tvalid (out_valid),
        .i_m_axis_tready (out_ready),
        .o_m_axis_tdata  (out_data)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial begin
        #1_000_000;
        $display("Test completed with failures");
        $finish;
    end

    task automatic report_fault(string what, int unsigned got, int unsigned want);
        n_faults++;
        $display("%0t word %0d: %s got %0h expected %0h", $time, n_outputs, what, got, want);
    endtask

    // Applies one event to the player model and returns the outputs it leaves behind.
    function automatic t_result advance_player(logic [1:0] mode, t_item it);
        t_result     r;
        int unsigned vol;
        int unsigned dur;
        int unsigned nxt;
        int          s;
        case (mode)
            MODE_TICK: begin
                if (pl_elapsed != '1)
                    pl_elapsed = pl_elapsed + 24'd1;
                pl_sample = pl_sample + 5'd1;
                if (pl_sample >= VOL_EVERY) begin
                    vol       = it.adc_sample * VOL_FULL / ADC_FULL;
                    pl_volume = 7'((vol > VOL_FULL) ? VOL_FULL : vol);
                    pl_sample = '0;
                end
                if (pl_armed) begin
                    // pending restart: next song, its LED, back to the first note
                    pl_tone  = 1'b0;
                    pl_song  = (pl_song >= SONG_COUNT) ? 3'd0 : pl_song + 3'd1;
                    pl_leds  = (pl_song + LED_OFFSET < 8) ? 8'(1 << (pl_song + LED_OFFSET))
                                                          : 8'h00;
                    pl_note  = '0;
                    pl_phase = PH_START;
                    pl_armed = 1'b0;
                end else if (pl_song != 3'd0) begin
                    s = pl_song - 1;
                    case (pl_phase)
                        PH_START: begin
                            pl_elapsed = '0;
                            // a rest leaves the tone off and the old period in place
                            if (pl_note_period[s][pl_note] != 16'd0) begin
                                pl_period = pl_note_period[s][pl_note];
                                pl_tone   = 1'b1;
                            end
                            pl_phase = PH_SOUND;
                        end
                        PH_SOUND: begin
                            dur = int'(pl_unit[s]) * int'(pl_note_len[s][pl_note]);
                            if (pl_elapsed >= dur) begin
                                pl_tone    = 1'b0;
                                pl_phase   = PH_GAP;
                                pl_elapsed = '0;
                            end
                        end
                        PH_GAP: begin
                            if (pl_elapsed >= pl_gap[s]) begin
                                nxt = pl_note + 1;
                                if (nxt >= pl_count[s] || nxt >= NOTE_SLOTS)
                                    nxt = 0;
                                pl_note  = nxt[7:0];
                                pl_phase = PH_START;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            MODE_BUTTON: begin
                pl_armed = 1'b1;
            end
            MODE_NOTE: begin
                pl_note_period[it.song_slot][it.note_index] = it.note_period;
                pl_note_len[it.song_slot][it.note_index]    = it.note_length;
                note_loaded[it.song_slot][it.note_index]    = 1'b1;
                while (loaded_run[it.song_slot] < NOTE_SLOTS &&
                       note_loaded[it.song_slot][loaded_run[it.song_slot]])
                    loaded_run[it.song_slot]++;
            end
            default: begin
                pl_unit[it.song_slot]  = it.unit_ticks;
                pl_gap[it.song_slot]   = it.gap_ticks;
                pl_count[it.song_slot] = it.note_count;
            end
        endcase
        r.tone_on        = pl_tone;
        r.tone_period    = pl_period;
        r.volume_percent = pl_volume;
        r.led_mask       = pl_leds;
        r.current_song   = pl_song;
        r.current_note   = pl_note;
        return r;
    endfunction

    // Offers one event word, holding it until taken; its outputs are queued on acceptance.
    task automatic send_word(logic [1:0] mode, t_item it, bit typed = 1'b0, t_result want = '0);
        while ($urandom_range(99) < src_idle) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_kind  <= mode;
        in_data  <= {1'b0, it.note_count, it.gap_ticks, it.unit_ticks, it.note_length,
                     it.note_period, it.note_index, it.song_slot, it.adc_sample};
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (typed) begin
            void'(advance_player(mode, it));
            due_outputs.push_back(want);
        end else begin
            due_outputs.push_back(advance_player(mode, it));
        end
        n_sent++;
    endtask

    function automatic t_item noise_item();
        logic [95:0] r;
        r = {$urandom(), $urandom(), $urandom()};
        return r[$bits(t_item)-1:0];
    endfunction

    function automatic logic [11:0] pick_adc();
        case ($urandom_range(9))
            0:       return 12'h000;
            1:       return 12'hFFF;
            default: return 12'($urandom_range(4095));
        endcase
    endfunction

    function automatic logic [15:0] pick_period();
        case ($urandom_range(19))
            0, 1, 2: return 16'h0000;
            3:       return 16'hFFFF;
            default: return 16'($urandom_range(1, 65535));
        endcase
    endfunction

    // mostly short notes so songs move along; now and then the longest
    function automatic logic [7:0] pick_length();
        case ($urandom_range(19))
            0:       return 8'hFF;
            1, 2:    return 8'($urandom_range(4, 15));
            default: return 8'($urandom_range(3));
        endcase
    endfunction

    function automatic logic [15:0] pick_ticks();
        case ($urandom_range(19))
            0:       return 16'hFFFF;
            1:       return 16'($urandom_range(65535));
            default: return 16'($urandom_range(3));
        endcase
    endfunction

    // a full song may take any count, wrapping at the store size; otherwise stay in the run
    function automatic logic [8:0] pick_count(logic [1:0] slot);
        int run;
        run = loaded_run[slot];
        if (run >= NOTE_SLOTS)
            return 9'($urandom_range(511));
        return ($urandom_range(1) != 0) ? 9'(run) : 9'($urandom_range(run));
    endfunction

    task automatic send_tick();
        t_item it;
        it            = noise_item();
        it.adc_sample = pick_adc();
        send_word(MODE_TICK, it);
    endtask

    task automatic send_button();
        send_word(MODE_BUTTON, noise_item());
    endtask

    task automatic send_note(logic [1:0] slot, logic [7:0] idx, logic [15:0] period,
                             logic [7:0] len);
        t_item it;
        it             = noise_item();
        it.song_slot   = slot;
        it.note_index  = idx;
        it.note_period = period;
        it.note_length = len;
        send_word(MODE_NOTE, it);
    endtask

    task automatic send_song(logic [1:0] slot, logic [15:0] unit, logic [15:0] gap,
                             logic [8:0] count);
        t_item it;
        it            = noise_item();
        it.song_slot  = slot;
        it.unit_ticks = unit;
        it.gap_ticks  = gap;
        it.note_count = count;
        send_word(MODE_SONG, it);
    endtask

    task automatic add_row(logic [1:0] mode, logic [1:0] slot, logic [7:0] idx,
                           logic [15:0] a, logic [15:0] b, logic [8:0] count,
                           logic [11:0] adc, bit typed = 1'b0, t_result want = '0);
        t_script_row row;
        row.item             = '0;
        row.mode             = mode;
        row.item.adc_sample  = adc;
        row.item.song_slot   = slot;
        row.item.note_index  = idx;
        row.item.note_period = a;
        row.item.note_length = b[7:0];
        row.item.unit_ticks  = a;
        row.item.gap_ticks   = b;
        row.item.note_count  = count;
        row.typed            = typed;
        row.want             = want;
        script.push_back(row);
    endtask

    function automatic t_result shows(bit tone, logic [15:0] period, logic [7:0] leds,
                                      logic [2:0] song, logic [7:0] note);
        t_result r;
        r.tone_on        = tone;
        r.tone_period    = period;
        r.volume_percent = '0;
        r.led_mask       = leds;
        r.current_song   = song;
        r.current_note   = note;
        return r;
    endfunction

    // Fills one song's store end to end, makes it wrap at the store size and plays it round.
    task automatic fill_song(logic [1:0] slot);
        while (loaded_run[slot] < NOTE_SLOTS)
            send_note(slot, 8'(loaded_run[slot]), pick_period(), 8'($urandom_range(255)));
        // zero unit and gap: three ticks per note
        send_song(slot, 16'd0, 16'd0, ($urandom_range(1) != 0) ? 9'd256 : 9'd511);
        while (pl_song != 3'(slot) + 3'd1) begin
            send_button();
            send_tick();
        end
        repeat (3 * NOTE_SLOTS + 12)
            send_tick();
    endtask

    // well-formed load: a few notes extending a song, usually followed by its settings
    task automatic load_episode();
        logic [1:0] slot;
        int         idx;
        slot = 2'($urandom_range(SONG_COUNT - 1));
        repeat ($urandom_range(1, 12)) begin
            idx = (loaded_run[slot] < NOTE_SLOTS && $urandom_range(99) < 80)
                  ? loaded_run[slot] : $urandom_range(NOTE_SLOTS - 1);
            send_note(slot, 8'(idx), pick_period(), pick_length());
        end
        if ($urandom_range(99) < 70)
            send_song(slot, pick_ticks(), pick_ticks(), pick_count(slot));
    endtask

    task automatic play_episode();
        if ($urandom_range(99) < 40) begin
            send_button();
            if ($urandom_range(99) < 15)
                send_button();
        end
        repeat ($urandom_range(5, 40))
            send_tick();
    endtask

    task automatic noise_burst();
        t_item      it;
        logic [1:0] mode;
        repeat ($urandom_range(1, 6)) begin
            it   = noise_item();
            mode = 2'($urandom_range(3));
            if (mode == MODE_SONG) begin
                it.unit_ticks = pick_ticks();
                it.gap_ticks  = pick_ticks();
                it.note_count = pick_count(it.song_slot);
            end
            send_word(mode, it);
        end
    endtask

    task automatic random_run(int n);
        int stop;
        stop = n_sent + n;
        while (n_sent < stop) begin
            case ($urandom_range(9))
                0, 1, 2:       load_episode();
                3, 4, 5, 6, 7: play_episode();
                default:       noise_burst();
            endcase
        end
    endtask

    // sender stands back until every outstanding word has come out
    task automatic wait_drain();
        in_valid <= 1'b0;
        while (due_outputs.size() != 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
    endtask

    // Output side: checks each accepted word against the oldest prediction, then picks
    // the next ready, with the long hold-off taking precedence over random stalls.
    always @(posedge clk) begin : take_outputs
        t_result got;
        t_result want;
        if (rst_n && out_valid && out_ready) begin
            got.tone_on        = out_data[0];
            got.tone_period    = out_data[16:1];
            got.volume_percent = out_data[23:17];
            got.led_mask       = out_data[31:24];
            got.current_song   = out_data[34:32];
            got.current_note   = out_data[42:35];
            if (due_outputs.size() == 0) begin
                report_fault("word with nothing outstanding", out_data[31:0], 0);
            end else begin
                want = due_outputs.pop_front();
                if (got.tone_on != want.tone_on)
                    report_fault("tone_on", got.tone_on, want.tone_on);
                if (got.tone_period != want.tone_period)
                    report_fault("tone_period", got.tone_period, want.tone_period);
                if (got.volume_percent != want.volume_percent)
                    report_fault("volume_percent", got.volume_percent, want.volume_percent);
                if (got.led_mask != want.led_mask)
                    report_fault("led_mask", got.led_mask, want.led_mask);
                if (got.current_song != want.current_song)
                    report_fault("current_song", got.current_song, want.current_song);
                if (got.current_note != want.current_note)
                    report_fault("current_note", got.current_note, want.current_note);
            end
            n_outputs++;
        end
        if (hold_kick != hold_seen) begin
            hold_seen <= hold_kick;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= dst_stall);
        end
    end

    initial begin
        // Scripted opening. Loads note 0 of every song and settings for all four before
        // any button, so every song the player can reach has something to read.
        //      mode         slot  idx     a         b         count  adc
        add_row(MODE_TICK,   2'd0, 8'd0,   16'h0000, 16'h0000, 9'd0,  12'h000, 1'b1, '0);
        add_row(MODE_NOTE,   2'd0, 8'd0,   16'hFFFF, 16'h00FF, 9'd0,  12'hFFF, 1'b1, '0);
        add_row(MODE_NOTE,   2'd0, 8'd1,   16'h0000, 16'h0001, 9'd0,  12'h000, 1'b1, '0);
        add_row(MODE_NOTE,   2'd1, 8'd0,   16'h0001, 16'h0000, 9'd0,  12'h000, 1'b1, '0);
        add_row(MODE_NOTE,   2'd2, 8'd0,   16'h8000, 16'h0002, 9'd0,  12'h000, 1'b1, '0);
        add_row(MODE_NOTE,   2'd3, 8'd0,   16'h1234, 16'h0000, 9'd0,  12'h000, 1'b1, '0);
        add_row(MODE_NOTE,   2'd3, 8'hFF,  16'hFFFF, 16'h00FF, 9'd0,  12'h000, 1'b1, '0);
        add_row(MODE_SONG,   2'd0, 8'd0,   16'h0000, 16'h0000, 9'd2,  12'h000, 1'b1, '0);
        // zero count keeps replaying note 0
        add_row(MODE_SONG,   2'd1, 8'd0,   16'hFFFF, 16'hFFFF, 9'd0,  12'h000, 1'b1, '0);
        add_row(MODE_SONG,   2'd2, 8'd0,   16'h0001, 16'h0001, 9'd1,  12'h000, 1'b1, '0);
        add_row(MODE_SONG,   2'd3, 8'd0,   16'h0000, 16'h0000, 9'd1,  12'h000, 1'b1, '0);
        // second press while armed: still only one song step
        add_row(MODE_BUTTON, 2'd0, 8'd0,   16'h0000, 16'h0000, 9'd0,  12'h000, 1'b1, '0);
        add_row(MODE_BUTTON, 2'd0, 8'd0,   16'h0000, 16'h0000, 9'd0,  12'h000, 1'b1, '0);
        add_row(MODE_TICK,   2'd0, 8'd0,   16'h0000, 16'h0000, 9'd0,  12'hFFF, 1'b1,
                shows(1'b0, 16'h0000, 8'h10, 3'd1, 8'd0));
        add_row(MODE_TICK,   2'd0, 8'd0,   16'h0000, 16'h0000, 9'd0,  12'h000, 1'b1,
                shows(1'b1, 16'hFFFF, 8'h10, 3'd1, 8'd0));
        // zero-length note, then the rest at note 1, then the wrap at a count of 2
        repeat (5)
            add_row(MODE_TICK, 2'd0, 8'd0, 16'h0000, 16'h0000, 9'd0,  12'hAAA);
        add_row(MODE_BUTTON, 2'd0, 8'd0,   16'h0000, 16'h0000, 9'd0,  12'h555);
        // song 2: full unit, zero length, then parked in a full-length gap
        repeat (4)
            add_row(MODE_TICK, 2'd0, 8'd0, 16'h0000, 16'h0000, 9'd0,  12'h555);

        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // no idling on either side
        foreach (script[i])
            send_word(script[i].mode, script[i].item, script[i].typed, script[i].want);
        fill_song(2'd0);
        // receiver holds off for a long stretch while words keep coming
        hold_kick = ~hold_kick;
        random_run(150);
        wait_drain();

        // sender mostly idle
        src_idle  = 80;
        random_run(200);
        wait_drain();

        // receiver mostly stalled, with a full drain halfway
        src_idle  = 0;
        dst_stall = 80;
        random_run(100);
        wait_drain();
        random_run(100);
        wait_drain();

        // both sides gappy
        src_idle  = 27;
        dst_stall = 27;
        random_run(200);
        wait_drain();

        repeat (20)
            @(posedge clk);
        if (due_outputs.size() != 0)
            report_fault("words never delivered", due_outputs.size(), 0);
        if (n_faults == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
